/* sv/modexp_pkg.sv */
// Package for the modular exponentiation block: constants, state and operand-select types.
`default_nettype none
package modexp_pkg;

  localparam int unsigned VAL_W    = 30;
  localparam int unsigned EXP_BITS = 30;
  localparam int unsigned MUL_W    = 31;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned RED_W    = 32;

  localparam logic [VAL_W-1:0]  PRIME      = 30'd998244353;
  localparam logic [RED_W-1:0]  PRIME_R    = 32'd998244353;
  localparam logic [RED_W-1:0]  PRIME_X2   = 32'(64'd2 * 64'd998244353);
  localparam logic [MUL_W-1:0]  RECIP_MU   = 31'((64'd1 << 60) / 64'd998244353);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QEST,
    ST_QP,
    ST_RED,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_OPER,
    MS_QEST,
    MS_QP
  } mul_src_t;

endpackage
`default_nettype wire

/* sv/modular_exponentiation.sv */
// Modular exponentiation mod 998244353: square-and-multiply on one shared 31x31 multiplier.
// Each modular multiply steps through the MUL, QEST, QP and RED states: product, reciprocal
// quotient estimate, quotient times prime, subtract and correct. One word is in flight; the
// next is taken in idle once the result loads, and a 30-bit all-ones exponent costs
// 30 multiplies and 29 squares.
// Reset (rst_n low, synchronous) returns to idle and drops any pending output word.
`default_nettype none
module modular_exponentiation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [29:0] in_base_value,
  input  wire logic [29:0] in_exponent,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [29:0]      out_power_mod
);

  modexp_pkg::state_t   state_r, state_nxt;
  modexp_pkg::mul_src_t mul_src;
  logic op_sqr_r, op_sqr_nxt;
  logic out_valid_r;
  logic load_en, mul_en, qest_en, red_en, out_load;

  logic [modexp_pkg::VAL_W-1:0]    base_r, acc_r, out_power_mod_r;
  logic [modexp_pkg::EXP_BITS-1:0] exp_r;
  logic [modexp_pkg::PROD_W-1:0]   mul_r, mul_p;
  logic [modexp_pkg::RED_W-1:0]    x_lo_r, diff, red_full;
  logic [modexp_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [modexp_pkg::VAL_W-1:0]    base_in_red, red_val;

  always_comb begin
    state_nxt  = state_r;
    op_sqr_nxt = op_sqr_r;
    unique case (state_r)
      modexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_exponent[modexp_pkg::EXP_BITS-1:0] == '0) begin
            state_nxt = modexp_pkg::ST_DONE;
          end else begin
            state_nxt  = modexp_pkg::ST_MUL;
            op_sqr_nxt = !in_exponent[0];
          end
        end
      end
      modexp_pkg::ST_MUL:  state_nxt = modexp_pkg::ST_QEST;
      modexp_pkg::ST_QEST: state_nxt = modexp_pkg::ST_QP;
      modexp_pkg::ST_QP:   state_nxt = modexp_pkg::ST_RED;
      modexp_pkg::ST_RED: begin
        if (op_sqr_r) begin
          state_nxt  = modexp_pkg::ST_MUL;
          op_sqr_nxt = !exp_r[1];
        end else if (exp_r[modexp_pkg::EXP_BITS-1:1] == '0) begin
          state_nxt = modexp_pkg::ST_DONE;
        end else begin
          state_nxt  = modexp_pkg::ST_MUL;
          op_sqr_nxt = 1'b1;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = modexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = modexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_en  = 1'b0;
    mul_en   = 1'b0;
    qest_en  = 1'b0;
    red_en   = 1'b0;
    out_load = 1'b0;
    mul_src  = modexp_pkg::MS_OPER;
    unique case (state_r)
      modexp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        load_en  = in_valid;
      end
      modexp_pkg::ST_MUL: begin
        mul_en = 1'b1;
      end
      modexp_pkg::ST_QEST: begin
        mul_en  = 1'b1;
        qest_en = 1'b1;
        mul_src = modexp_pkg::MS_QEST;
      end
      modexp_pkg::ST_QP: begin
        mul_en  = 1'b1;
        mul_src = modexp_pkg::MS_QP;
      end
      modexp_pkg::ST_RED: begin
        red_en = 1'b1;
      end
      modexp_pkg::ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    unique case (mul_src)
      modexp_pkg::MS_OPER: begin
        mul_a = {1'b0, (op_sqr_r ? base_r : acc_r)};
        mul_b = {1'b0, base_r};
      end
      modexp_pkg::MS_QEST: begin
        mul_a = mul_r[59:29];
        mul_b = modexp_pkg::RECIP_MU;
      end
      modexp_pkg::MS_QP: begin
        mul_a = mul_r[61:31];
        mul_b = {1'b0, modexp_pkg::PRIME};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{modexp_pkg::MUL_W{1'b0}}, mul_a} * {{modexp_pkg::MUL_W{1'b0}}, mul_b};

  assign diff = x_lo_r - mul_r[modexp_pkg::RED_W-1:0];

  always_comb begin
    priority if (diff >= modexp_pkg::PRIME_X2) begin
      red_full = diff - modexp_pkg::PRIME_X2;
    end else if (diff >= modexp_pkg::PRIME_R) begin
      red_full = diff - modexp_pkg::PRIME_R;
    end else begin
      red_full = diff;
    end
  end

  assign red_val     = red_full[modexp_pkg::VAL_W-1:0];
  assign base_in_red = (in_base_value >= modexp_pkg::PRIME) ?
                       (in_base_value - modexp_pkg::PRIME) : in_base_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= modexp_pkg::ST_IDLE;
      op_sqr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_sqr_r <= op_sqr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      base_r <= base_in_red;
      acc_r  <= modexp_pkg::VAL_W'(1);
      exp_r  <= in_exponent[modexp_pkg::EXP_BITS-1:0];
    end else if (red_en) begin
      if (op_sqr_r) begin
        base_r <= red_val;
        exp_r  <= exp_r >> 1;
      end else begin
        acc_r <= red_val;
      end
    end
    if (mul_en) begin
      mul_r <= mul_p;
    end
    if (qest_en) begin
      x_lo_r <= mul_r[modexp_pkg::RED_W-1:0];
    end
    if (out_load) begin
      out_power_mod_r <= acc_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_power_mod_r;

endmodule
`default_nettype wire

/* sim/tb_modular_exponentiation.sv */
// Testbench for modular_exponentiation: directed, back-pressure and random power checks.
module tb_modular_exponentiation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PRIME_MOD = 64'd998244353;
  localparam int unsigned EXP_W = 30;
  localparam logic [29:0] ALL_ONES = 30'h3FFFFFFF;
  localparam logic [29:0] PRIME_30 = 30'd998244353;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  typedef struct {
    logic [29:0] base;
    logic [29:0] expo;
    logic [29:0] power;
  } power_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [29:0] in_base_value = '0;
  logic [29:0] in_exponent = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [29:0] out_power_mod;

  power_entry_t pending_powers[$];
  power_entry_t oldest_power;
  int unsigned mismatches = 0;
  int unsigned powers_checked = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_len = 0;
  int unsigned held_cycles = 0;
  bit quiet = 1'b0;

  always #1 clk = ~clk;

  modular_exponentiation dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_base_value(in_base_value),
    .in_exponent(in_exponent),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_power_mod(out_power_mod)
  );

  function automatic logic [29:0] power_mod_prime(logic [29:0] b, logic [29:0] e);
    longint unsigned square;
    longint unsigned acc;
    square = b;
    square = square % PRIME_MOD;
    acc = 1;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = (acc * square) % PRIME_MOD;
      square = (square * square) % PRIME_MOD;
    end
    return acc[29:0];
  endfunction

  always @(posedge clk) begin
    if (held_cycles < hold_off_len) begin
      out_stall <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual power_mod %0d",
                 $realtime, out_power_mod);
      end else begin
        oldest_power = pending_powers.pop_front();
        powers_checked++;
        if (out_power_mod !== oldest_power.power) begin
          mismatches++;
          $display("%0t: power_mod for base %0d exp %0d: expected %0d, actual %0d",
                   $realtime, oldest_power.base, oldest_power.expo,
                   oldest_power.power, out_power_mod);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $realtime, cycle_count, pending_powers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input logic [29:0] b, input logic [29:0] e);
    int unsigned gap;
    power_entry_t sent_power;
    gap = 0;
    if (!quiet && $urandom_range(99) < 8) gap = $urandom_range(60, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_value <= b;
    in_exponent <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_power.base = b;
    sent_power.expo = e;
    sent_power.power = power_mod_prime(b, e);
    pending_powers.insert(pending_powers.size(), sent_power);
    words_sent++;
  endtask

  task automatic test_edge_cases();
    send_word(30'd0, 30'd0);
    send_word(ALL_ONES, 30'd0);
    send_word(PRIME_30, 30'd0);
    send_word(30'd0, 30'd1);
    send_word(30'd0, ALL_ONES);
    send_word(30'd1, ALL_ONES);
    send_word(ALL_ONES, ALL_ONES);
    send_word(ALL_ONES, 30'd1);
    send_word(PRIME_30, 30'd3);
    send_word(PRIME_30 + 30'd1, ALL_ONES);
    send_word(PRIME_30 - 30'd1, 30'd2);
    send_word(PRIME_30 - 30'd1, 30'd1);
    send_word(PRIME_30 - 30'd1, 30'd7);
    send_word(30'd3, PRIME_30 - 30'd1);
    send_word(30'd2, 30'd29);
    send_word(30'd2, 30'h20000000);
    send_word(30'h20000000, 30'h2AAAAAAA);
    send_word(30'h15555555, 30'h15555555);
    send_word(30'h2AAAAAAA, 30'h3FFF0000);
    send_word(30'd12345, 30'd1);
  endtask

  task automatic test_random(input int unsigned count, input bit no_idle);
    logic [29:0] b;
    logic [29:0] e;
    quiet = no_idle;
    repeat (count) begin
      case ($urandom_range(9))
        0: b = 30'($urandom_range(3));
        1: b = 30'(PRIME_MOD - 2 + $urandom_range(4));
        2: b = ALL_ONES - 30'($urandom_range(3));
        default: b = 30'($urandom());
      endcase
      case ($urandom_range(9))
        0, 1, 2: e = 30'($urandom_range(255));
        3: e = ALL_ONES ^ 30'($urandom_range(15));
        default: e = 30'($urandom());
      endcase
      send_word(b, e);
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_hold_off();
    quiet = 1'b1;
    hold_off_len = HOLD_OFF_CYCLES;
    repeat (12) send_word(30'($urandom()), 30'($urandom()));
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_random(250, 1'b1);
    test_output_hold_off();
    test_random(880, 1'b0);
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results of %0d words: edge operands, base reduction, p-1 power, random",
             powers_checked, words_sent);
    $display("Output held off %0d cycles to back up the input, random idling elsewhere",
             held_cycles);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
